@@ src/dequ_pkg.sv @@
package dequ_pkg;

  localparam int unsigned DequDepth = 64;
  localparam int unsigned DataW     = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_POP_FRONT  = 3'd1,
    REQ_PUSH_BACK  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DUMP       = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_e;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] data;
    logic               last;
  } res_t;

endpackage

@@ src/double_ended_queue_unit.sv @@
// Channel   Dir  tdata                 tuser             tlast
// s_axis    in   [31:0] value          [2:0] req_type    -
// m_axis    out  [31:0] data_out       [1:0] status      last
//
// Push and a failed pop or empty dump: result registered at accept.
// Pop: ring read, then result. Dump: one result per entry at full output rate,
// one ring read per entry through the single read port.
// Reset clears head and count; ring contents stay undefined until written.
// Output stalls freeze the dump and pop sequencer; input is taken only when
// the sequencer is idle and the result register is free or draining.
module double_ended_queue_unit import dequ_pkg::*; #(
  parameter int unsigned DEPTH = DequDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] data_out
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] dump_off_q, dump_off_d;

  logic          in_ready, in_acc, res_free, full, empty, dump_last;
  logic [AW-1:0] off, slot, head_dec, head_inc;
  logic [AW:0]   slot_sum;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  logic          res_load, res_valid;
  res_t          res_new, res_out;

  assign full     = count_q == CW'(DEPTH);
  assign empty    = count_q == '0;
  assign in_ready = (state_q == S_IDLE) && res_free;
  assign in_acc   = s_axis_tvalid_i && in_ready;

  assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign dump_last = CW'(dump_off_q) == count_q - 1'b1;

  // ring offset relative to head; always below DEPTH where it is used
  always_comb begin
    off = '0;
    if (state_q == S_DUMP) begin
      off = dump_off_q + 1'b1;
    end else if (s_axis_tuser_i == REQ_PUSH_BACK) begin
      off = count_q[AW-1:0];
    end else if (s_axis_tuser_i == REQ_POP_BACK) begin
      off = AW'(count_q - 1'b1);
    end
  end

  assign slot_sum = {1'b0, head_q} + {1'b0, off};
  assign slot     = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                 : slot_sum[AW-1:0];

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    dump_off_d = dump_off_q;
    ram_we     = 1'b0;
    ram_waddr  = slot;
    ram_re     = 1'b0;
    ram_raddr  = slot;
    res_load   = 1'b0;
    res_new    = '{status: ST_OK, data: '0, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser_i)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              res_load = 1'b1;
              if (full) begin
                res_new.status = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
                if (s_axis_tuser_i == REQ_PUSH_FRONT) begin
                  ram_waddr = head_dec;
                  head_d    = head_dec;
                end
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (empty) begin
                res_load       = 1'b1;
                res_new.status = ST_EMPTY;
              end else begin
                ram_re  = 1'b1;
                count_d = count_q - 1'b1;
                state_d = S_POP;
                if (s_axis_tuser_i == REQ_POP_FRONT) begin
                  ram_raddr = head_q;
                  head_d    = head_inc;
                end
              end
            end
            REQ_DUMP: begin
              if (empty) begin
                res_load       = 1'b1;
                res_new.status = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = head_q;
                dump_off_d = '0;
                state_d    = S_DUMP;
              end
            end
            default: begin
              // unknown request: dropped without a result
            end
          endcase
        end
      end
      S_POP: begin
        if (res_free) begin
          res_load     = 1'b1;
          res_new.data = ram_rdata;
          state_d      = S_IDLE;
        end
      end
      S_DUMP: begin
        if (res_free) begin
          res_load     = 1'b1;
          res_new.data = ram_rdata;
          res_new.last = dump_last;
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            ram_re     = 1'b1;
            dump_off_d = dump_off_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      dump_off_q <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      dump_off_q <= dump_off_d;
    end
  end

  dequ_ram #(
    .WIDTH (DataW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dequ_res_reg u_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (res_new),
    .ready_i (m_axis_tready_i),
    .valid_o (res_valid),
    .res_o   (res_out),
    .free_o  (res_free)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = res_valid;
  assign m_axis_tdata_o  = res_out.data;
  assign m_axis_tuser_o  = res_out.status;
  assign m_axis_tlast_o  = res_out.last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> !res_valid)
    else $error("pop result would overwrite pending result");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !full &&
    (s_axis_tuser_i == REQ_PUSH_FRONT || s_axis_tuser_i == REQ_PUSH_BACK)
    |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the queue");

  a_dump_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |=> $stable(count_q) && $stable(head_q))
    else $error("queue changed during dump");

endmodule

@@ src/dequ_ram.sv @@
module dequ_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/dequ_res_reg.sv @@
module dequ_res_reg import dequ_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic valid_o,
  output res_t res_o,
  output logic free_o
);

  logic valid_q, valid_d;
  res_t res_q, res_d;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (valid_q && ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ verif/tb_double_ended_queue_unit.sv @@
module tb_double_ended_queue_unit;
  import dequ_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned ItemsPerPhase = 113;
  localparam int unsigned DrainCycles = 20;

  // Tracks ring contents and queues up the results each request must produce.
  class deque_scoreboard;
    logic [DataW-1:0] ring [DequDepth];
    int unsigned      head;
    int unsigned      count;
    res_t             pending [$];
    int unsigned      errors;

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function void push_result(status_e st, logic [DataW-1:0] data, logic last);
      res_t r;
      r.status = st;
      r.data   = data;
      r.last   = last;
      pending.push_back(r);
    endfunction

    function void note_request(logic [2:0] req, logic [DataW-1:0] val);
      int unsigned slot;
      case (req)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (count >= DequDepth) begin
            push_result(ST_FULL, '0, 1'b1);
          end else begin
            if (req == REQ_PUSH_FRONT) begin
              head = (head + DequDepth - 1) % DequDepth;
              slot = head;
            end else begin
              slot = (head + count) % DequDepth;
            end
            ring[slot] = val;
            count++;
            push_result(ST_OK, '0, 1'b1);
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (count == 0) begin
            push_result(ST_EMPTY, '0, 1'b1);
          end else begin
            if (req == REQ_POP_FRONT) begin
              slot = head;
              head = (head + 1) % DequDepth;
            end else begin
              slot = (head + count - 1) % DequDepth;
            end
            count--;
            push_result(ST_OK, ring[slot], 1'b1);
          end
        end
        REQ_DUMP: begin
          if (count == 0) begin
            push_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < count; i++) begin
              push_result(ST_OK, ring[(head + i) % DequDepth], (i + 1 == count));
            end
          end
        end
        default: ;  // undefined request codes produce nothing
      endcase
    endfunction

    function void check_result(status_e st, logic [DataW-1:0] data, logic last);
      res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%h last=%b", $time, st, data, last);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (st !== exp_r.status) begin
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, exp_r.status, st);
        errors++;
      end
      if (data !== exp_r.data) begin
        $display("%0t: data mismatch expected=%h actual=%h", $time, exp_r.data, data);
        errors++;
      end
      if (last !== exp_r.last) begin
        $display("%0t: last mismatch expected=%b actual=%b", $time, exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  deque_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  bit          filling = 1'b1;

  double_ended_queue_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: check on the edge, then pick the next tready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(status_e'(m_axis_tuser_o), m_axis_tdata_o, m_axis_tlast_o);
    end
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(input logic [2:0] req, input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= val;
    s_axis_tuser_i  <= req;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(req, val);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(1) ? 32'h0000_0000 : 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Biased walk: fill toward full, then drain toward empty, lingering at the ends.
  task automatic send_random_request();
    int unsigned pick;
    logic [2:0]  req;
    if (filling && sb.count >= DequDepth && $urandom_range(3) == 0) filling = 1'b0;
    if (!filling && sb.count == 0 && $urandom_range(3) == 0) filling = 1'b1;
    pick = $urandom_range(99);
    if (pick < 2) begin
      req = 3'($urandom_range(7, 5));
    end else if (pick < 9) begin
      req = REQ_DUMP;
    end else if (pick < 80) begin
      if (filling) req = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
      else req = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
    end else begin
      if (filling) req = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
      else req = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    end
    send_request(req, pick_value());
  endtask

  initial begin
    int unsigned sent;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= REQ_PUSH_FRONT;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-queue cases, ignored codes, extreme values, front wrap below slot zero.
    send_request(REQ_DUMP, 32'h1234_5678);
    send_request(REQ_POP_FRONT, 32'hffff_ffff);
    send_request(REQ_POP_BACK, 32'h0);
    send_request(3'd5, 32'hdead_beef);
    send_request(3'd6, 32'h0);
    send_request(3'd7, 32'hffff_ffff);
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_PUSH_BACK, 32'h7fff_ffff);
    send_request(REQ_PUSH_FRONT, 32'h0000_0000);
    send_request(REQ_PUSH_BACK, 32'hffff_ffff);
    send_request(REQ_DUMP, 32'h0);
    send_request(REQ_POP_BACK, 32'h0);
    send_request(REQ_POP_FRONT, 32'h0);
    send_request(REQ_PUSH_FRONT, 32'h5555_5555);
    send_request(REQ_PUSH_BACK, 32'haaaa_aaaa);
    send_request(REQ_DUMP, 32'h0);
    send_request(REQ_POP_FRONT, 32'h0);
    send_request(REQ_POP_BACK, 32'h0);
    send_request(REQ_POP_FRONT, 32'h0);
    send_request(REQ_POP_BACK, 32'h0);
    send_request(REQ_DUMP, 32'h0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // long receiver hold while the sender keeps sending requests, so the input backs up
      if (phase == 0) hold_asked++;
      sent = 0;
      while (sent < ItemsPerPhase) begin
        send_random_request();
        if (s_axis_tuser_i <= REQ_DUMP) sent++;
      end
    end

    s_axis_tvalid_i <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
